@@ hdl/sdspi_pkg.sv @@
package sdspi_pkg;

    localparam int CardBlocks = 16;
    localparam int BlkW       = $clog2(CardBlocks) > 0 ? $clog2(CardBlocks) : 1;
    localparam int StoreDepth = CardBlocks * 512;
    localparam int StoreAw    = BlkW + 9;
    localparam int ClearCount = StoreDepth;

    localparam logic [3:0] PH_WAIT_CMD    = 4'd0;
    localparam logic [3:0] PH_WAIT_ARG    = 4'd1;
    localparam logic [3:0] PH_WAIT_CRC    = 4'd2;
    localparam logic [3:0] PH_RESP_START  = 4'd3;
    localparam logic [3:0] PH_RESP_SEND   = 4'd4;
    localparam logic [3:0] PH_READ_START  = 4'd5;
    localparam logic [3:0] PH_READ        = 4'd6;
    localparam logic [3:0] PH_WRITE_START = 4'd7;
    localparam logic [3:0] PH_WRITE       = 4'd8;
    localparam logic [3:0] PH_COMMIT      = 4'd9;

    localparam logic [7:0] R1_IDLE  = 8'h01;
    localparam logic [7:0] R1_ILL   = 8'h04;
    localparam logic [7:0] R1_PARAM = 8'h40;
    localparam logic [7:0] TOKEN    = 8'hFE;
    localparam logic [7:0] FILL     = 8'hFF;

    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_IF_COND   = 6'd8;
    localparam logic [5:0] CMD_GET_SPEC  = 6'd9;
    localparam logic [5:0] CMD_GET_ID    = 6'd10;
    localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
    localparam logic [5:0] CMD_READ      = 6'd17;
    localparam logic [5:0] CMD_WRITE     = 6'd24;
    localparam logic [5:0] CMD_APP_OP    = 6'd41;
    localparam logic [5:0] CMD_APP       = 6'd55;
    localparam logic [5:0] CMD_GET_OCR   = 6'd58;

    localparam logic REG_OCR = 1'b0;
    localparam logic REG_HC  = 1'b1;

    typedef logic [7:0] t_byte;

    function automatic t_byte id_byte(input logic [3:0] i);
        t_byte r;
        case (i)
            4'd0: r = 8'h4B;  4'd1: r = 8'h57;  4'd2: r = 8'h41;  4'd3: r = 8'h53;
            4'd4: r = 8'h49;  4'd5: r = 8'h4D;  4'd6: r = 8'h43;  4'd7: r = 8'h44;
            4'd11: r = 8'h0C; 4'd12: r = 8'h91; 4'd13: r = 8'h06; 4'd14: r = 8'h0F;
            4'd15: r = 8'hFF;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/sd_spi_card_responder.sv @@
// Handshake: a request is accepted and its MISO byte is offered from a
// register on the next cycle; a new request is accepted in the same cycle
// the waiting byte is taken. Throughput: one request per cycle while the
// output is taken and no clearing pass runs; a finished block write stalls
// requests while the 512-byte buffer is copied into the card store over its
// single write port. Reset: synchronous, active low; a clearing pass follows.
module sd_spi_card_responder
    import sdspi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [7:0]  i_mosi_byte,
    input  logic        i_cs_level,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_miso_byte
);

    // Two memories hold the bulk state: the card store and the write buffer.
    // Both have registered reads. Block reads prefetch one byte ahead so the
    // data is ready when the host's next exchange asks for it.
    t_byte r_store [StoreDepth];
    t_byte r_wbuf  [512];

    logic [31:0] r_ocr;
    logic        r_hc;

    logic [3:0]  r_phase, n_phase;
    logic [5:0]  r_cmd, n_cmd;
    logic [31:0] r_arg, n_arg;
    logic [2:0]  r_argleft, n_argleft;
    t_byte       r_rep [5];
    t_byte       n_rep [5];
    logic [2:0]  r_repidx, n_repidx;
    logic [2:0]  r_repleft, n_repleft;
    logic [1:0]  r_dly, n_dly;
    logic [9:0]  r_rdleft, n_rdleft;
    logic [9:0]  r_rdidx, n_rdidx;
    logic        r_fromid, n_fromid;
    logic [9:0]  r_wrleft, n_wrleft;
    logic [8:0]  r_wridx, n_wridx;
    logic        r_app, n_app;

    logic                r_clr;
    logic [StoreAw-1:0]  r_clr_addr;
    logic [9:0]          r_cpy;       // commit sweep counter, bit 9 = last read issued
    t_byte               r_sdata;     // registered store read data
    t_byte               r_wdata;     // registered buffer read data
    logic [8:0]          r_cpy_wa;
    logic                r_cpy_wv;

    logic        r_ovalid;
    t_byte       r_obyte;

    logic        take;
    logic        xchg;
    logic        blk_ok;
    t_byte       miso;
    logic [8:0]  rd_off;

    assign o_ready = !r_clr && r_phase != PH_COMMIT && (!r_ovalid || i_ready);
    assign take    = i_valid && o_ready;
    assign xchg    = take && !i_func;
    assign blk_ok  = r_arg < 32'(CardBlocks);
    assign o_valid = r_ovalid;
    assign o_miso_byte = r_obyte;

    always_comb begin
        n_phase = r_phase; n_cmd = r_cmd; n_arg = r_arg; n_argleft = r_argleft;
        n_rep = r_rep; n_repidx = r_repidx; n_repleft = r_repleft; n_dly = r_dly;
        n_rdleft = r_rdleft; n_rdidx = r_rdidx; n_fromid = r_fromid;
        n_wrleft = r_wrleft; n_wridx = r_wridx; n_app = r_app;
        miso = FILL;
        // Output stage of the exchange.
        case (r_phase)
            PH_RESP_SEND: begin
                miso = r_rep[r_repidx < 3'd5 ? r_repidx : 3'd4];
                if (r_repleft > 3'd1) begin
                    n_repidx = r_repidx + 3'd1; n_repleft = r_repleft - 3'd1;
                end else if (r_rdleft != 10'd0) begin
                    n_phase = PH_READ_START;
                end else if (r_wrleft != 10'd0) begin
                    n_phase = PH_WRITE_START;
                end else begin
                    n_phase = PH_WAIT_CMD;
                end
            end
            PH_READ_START: begin
                miso = TOKEN; n_phase = PH_READ;
            end
            PH_READ: begin
                if (r_cmd == CMD_GET_SPEC) miso = FILL;
                else if (r_fromid) miso = id_byte(r_rdidx[3:0]);
                else if (r_rdidx[9] || !blk_ok) miso = FILL;
                else miso = r_sdata;
                if (r_rdleft > 10'd1) begin
                    n_rdidx = r_rdidx + 10'd1; n_rdleft = r_rdleft - 10'd1;
                end else begin
                    n_phase = PH_WAIT_CMD;
                end
            end
            PH_WAIT_CMD, PH_WAIT_ARG, PH_WAIT_CRC, PH_RESP_START,
            PH_WRITE_START, PH_WRITE: miso = FILL;
            default: n_phase = PH_WAIT_CMD;
        endcase
        // Input stage, in the phase left by the output stage.
        case (n_phase)
            PH_WAIT_CMD: begin
                if (!i_mosi_byte[7]) begin
                    n_cmd = i_mosi_byte[5:0]; n_argleft = 3'd4; n_phase = PH_WAIT_ARG;
                end
            end
            PH_WAIT_ARG: begin
                n_arg = {r_arg[23:0], i_mosi_byte};
                if (r_argleft > 3'd1) n_argleft = r_argleft - 3'd1;
                else begin
                    n_argleft = 3'd0; n_phase = PH_WAIT_CRC;
                end
            end
            PH_WAIT_CRC: begin
                n_repidx = 3'd0; n_repleft = 3'd1; n_dly = 2'd2;
                n_rdidx = 10'd0; n_rdleft = 10'd0; n_fromid = 1'b0;
                n_wridx = 9'd0; n_wrleft = 10'd0; n_phase = PH_RESP_START;
                n_app = 1'b0;
                case (r_cmd)
                    CMD_GO_IDLE: n_rep[0] = R1_IDLE;
                    CMD_APP: begin
                        n_rep[0] = R1_IDLE; n_app = 1'b1;
                    end
                    CMD_APP_OP: n_rep[0] = 8'h00;
                    CMD_GET_OCR: begin
                        n_repleft = 3'd5; n_rep[0] = 8'h00;
                        n_rep[1] = r_ocr[31:24]; n_rep[2] = r_ocr[23:16];
                        n_rep[3] = r_ocr[15:8];  n_rep[4] = r_ocr[7:0];
                    end
                    CMD_IF_COND: begin
                        n_repleft = 3'd5; n_rep[0] = R1_IDLE; n_rep[1] = 8'h00;
                        n_rep[2] = 8'h00; n_rep[3] = 8'h01; n_rep[4] = r_arg[7:0];
                    end
                    CMD_BLOCKLEN: n_rep[0] =
                        ((r_hc && r_arg != 32'd512) || r_arg > 32'd512) ? R1_PARAM : 8'h00;
                    CMD_GET_ID: begin
                        n_rep[0] = 8'h00; n_rdleft = 10'd16; n_fromid = 1'b1;
                    end
                    CMD_GET_SPEC: begin
                        n_rep[0] = 8'h00; n_rdleft = 10'd16;
                    end
                    CMD_READ: begin
                        n_app = r_app;
                        if (blk_ok) begin
                            n_rep[0] = 8'h00; n_rdleft = 10'd514;
                        end else n_rep[0] = R1_PARAM;
                    end
                    CMD_WRITE: begin
                        n_app = r_app;
                        if (blk_ok) begin
                            n_rep[0] = 8'h00; n_wrleft = 10'd512;
                        end else n_rep[0] = R1_PARAM;
                    end
                    default: n_rep[0] = R1_IDLE | R1_ILL;
                endcase
            end
            PH_RESP_START: begin
                if (r_dly > 2'd1) n_dly = r_dly - 2'd1;
                else n_phase = PH_RESP_SEND;
            end
            PH_WRITE_START: begin
                if (i_mosi_byte == TOKEN) n_phase = PH_WRITE;
            end
            PH_WRITE: begin
                if (r_wrleft > 10'd1) begin
                    n_wridx = r_wridx + 9'd1; n_wrleft = r_wrleft - 10'd1;
                end else begin
                    n_wrleft = 10'd0;
                    n_phase = blk_ok ? PH_COMMIT : PH_WAIT_CMD;
                end
            end
            default: ;
        endcase
    end

    // Prefetch address: the byte the next read exchange will send.
    always_comb begin
        if (r_phase == PH_READ) rd_off = n_rdidx[8:0];
        else rd_off = 9'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocr <= 32'hC0FF_8000; r_hc <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OCR: r_ocr <= i_cfg_data;
                REG_HC:  r_hc  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT_CMD; r_cmd <= '0; r_arg <= '0; r_argleft <= '0;
            r_repidx <= '0; r_repleft <= '0; r_dly <= '0; r_rdleft <= '0;
            r_rdidx <= '0; r_fromid <= 1'b0; r_wrleft <= '0; r_wridx <= '0;
            r_app <= 1'b0; r_ovalid <= 1'b0;
            r_clr <= 1'b1; r_clr_addr <= '0; r_cpy <= '0; r_cpy_wv <= 1'b0;
        end else begin
            r_ovalid <= take || (r_ovalid && !i_ready);
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + StoreAw'(1);
                if (r_clr_addr == StoreAw'(ClearCount - 1)) r_clr <= 1'b0;
            end
            // Commit sweep: read buffer entry k, write it to the store in the next cycle.
            r_cpy_wv <= r_phase == PH_COMMIT && !r_cpy[9];
            if (r_phase == PH_COMMIT) begin
                if (!r_cpy[9]) begin
                    r_cpy_wa <= r_cpy[8:0];
                    r_cpy <= r_cpy + 10'd1;
                end else begin
                    r_cpy <= '0; r_phase <= PH_WAIT_CMD;
                end
            end
            if (take) begin
                if (i_func) begin
                    if (i_cs_level) r_phase <= PH_WAIT_CMD;
                end else begin
                    r_phase <= n_phase; r_cmd <= n_cmd; r_arg <= n_arg;
                    r_argleft <= n_argleft; r_repidx <= n_repidx;
                    r_repleft <= n_repleft; r_dly <= n_dly; r_rdleft <= n_rdleft;
                    r_rdidx <= n_rdidx; r_fromid <= n_fromid; r_wrleft <= n_wrleft;
                    r_wridx <= n_wridx; r_app <= n_app;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_obyte <= i_func ? FILL : miso;
        if (xchg) r_rep <= n_rep;
    end

    // Write buffer: written by data bytes, read by the commit sweep.
    always_ff @(posedge i_clk) begin
        if (xchg && r_phase == PH_WRITE)
            r_wbuf[r_wridx] <= i_mosi_byte;
        r_wdata <= r_wbuf[r_cpy[8:0]];
    end

    // Card store: one write port (clear or commit), one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_clr) r_store[r_clr_addr] <= 8'h00;
        else if (r_cpy_wv) r_store[{r_arg[BlkW-1:0], r_cpy_wa}] <= r_wdata;
        if (xchg) r_sdata <= r_store[{n_arg[BlkW-1:0], rd_off}];
    end

endmodule
